### sv/assert_macros.svh
// Assertion macros shared by the AT response line parser RTL.
// No dependencies; the checks drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that is switched off while reset is held.
`define AT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("at_rlp assertion failed");
// Check that is live through reset as well.
`define AT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("at_rlp assertion failed");
`else
`define AT_ASSERT(lbl, clk, rst_n, prop)
`define AT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### sv/at_rlp_pkg.sv
// Package for the AT response line parser: types, character codes, prefix tables.
// No dependencies.
package at_rlp_pkg;

    localparam int unsigned LENGTH_BITS_DEF = 8;
    localparam int unsigned PFX_NUM   = 4;
    localparam int unsigned PFX_SLOTS = 16;

    // prefix slots
    localparam int unsigned P_NAME = 0;
    localparam int unsigned P_IPD  = 1;
    localparam int unsigned P_ADDR = 2;
    localparam int unsigned P_UP   = 3;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [3:0] SRC_MAX = 4'd9;
    localparam logic [7:0] POS_MAX = 8'hFF;

    localparam logic [1:0] KIND_NAME    = 2'd0;
    localparam logic [1:0] KIND_ADDR    = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_LINK_UP = 2'd3;

    localparam logic [7:0] PFX_LEN [PFX_NUM] = '{8'd8, 8'd5, 8'd14, 8'd11};

    localparam logic [7:0] PFX_TEXT [PFX_NUM][PFX_SLOTS] = '{
        '{"+", "C", "W", "J", "A", "P", ":", "\"",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"+", "I", "P", "D", ",", 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"+", "C", "I", "F", "S", "R", ":", "S",
          "T", "A", "I", "P", ",", "\"", 8'h00, 8'h00},
        '{"W", "I", "F", "I", " ", "G", "O", "T",
          " ", "I", "P", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    typedef enum logic [2:0] {
        MODE_MATCH,
        MODE_SKIP,
        MODE_NAME,
        MODE_ADDR,
        MODE_LINK,
        MODE_COUNT,
        MODE_DATA
    } t_mode;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic [3:0] src;
        logic [7:0] len;
    } t_result;

    // Prefixes whose character at this line position equals the byte.
    function automatic logic [PFX_NUM-1:0] prefix_hits(input logic [7:0] pos,
                                                       input logic [7:0] rx);
        logic [PFX_NUM-1:0] hits;
        for (int i = 0; i < PFX_NUM; i++) begin
            hits[i] = (pos < PFX_LEN[i]) && (rx == PFX_TEXT[i][pos[3:0]]);
        end
        return hits;
    endfunction

    // Prefixes whose last character sits at this line position.
    function automatic logic [PFX_NUM-1:0] prefix_ends(input logic [7:0] pos);
        logic [PFX_NUM-1:0] ends;
        for (int i = 0; i < PFX_NUM; i++) begin
            ends[i] = (pos == PFX_LEN[i] - 8'd1);
        end
        return ends;
    endfunction

endpackage

### sv/at_rlp_parse.sv
// Line parser core: per-byte state update and result generation.
// Depends on at_rlp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module at_rlp_parse
    import at_rlp_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  logic [7:0] i_byte,
    output logic    o_res_valid,
    output t_result o_res
);

    t_mode                  r_mode,  n_mode;
    logic [7:0]             r_pos,   n_pos;
    logic [PFX_NUM-1:0]     r_alive, n_alive;
    logic [3:0]             r_src,   n_src;
    logic [LENGTH_BITS-1:0] r_decl,  n_decl;
    logic [LENGTH_BITS-1:0] r_remain, n_remain;
    logic [7:0]             r_held,  n_held;
    logic                   r_held_vld, n_held_vld;
    logic                   r_closed, n_closed;

    logic                   is_nul, is_nl, is_quote, is_dig, active;
    logic [PFX_NUM-1:0]     alive_next, done;
    logic [7:0]             src_calc;
    logic [3:0]             src_sum;
    logic [LENGTH_BITS+3:0] decl_calc;
    logic [LENGTH_BITS-1:0] decl_sum;
    logic [LENGTH_BITS+7:0] decl_ext;
    logic [1:0]             field_kind;
    logic                   remain_one;

    assign is_nul   = (i_byte == CHAR_NUL);
    assign is_nl    = (i_byte == CHAR_NL);
    assign is_quote = (i_byte == CHAR_QUOTE);
    assign is_dig   = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
    assign active   = i_fire && !is_nul;

    assign alive_next = r_alive & prefix_hits(r_pos, i_byte);
    assign done       = alive_next & prefix_ends(r_pos);

    // value*10 + digit, saturating
    assign src_calc  = ({4'd0, r_src} << 3) + ({4'd0, r_src} << 1) + {4'd0, i_byte[3:0]};
    assign src_sum   = (src_calc > {4'd0, SRC_MAX}) ? SRC_MAX : src_calc[3:0];
    assign decl_calc = ({4'd0, r_decl} << 3) + ({4'd0, r_decl} << 1)
                     + {{LENGTH_BITS{1'b0}}, i_byte[3:0]};
    assign decl_sum  = (decl_calc > {4'd0, {LENGTH_BITS{1'b1}}}) ?
                       {LENGTH_BITS{1'b1}} : decl_calc[LENGTH_BITS-1:0];

    assign decl_ext   = {8'd0, r_decl};
    assign field_kind = (r_mode == MODE_NAME) ? KIND_NAME : KIND_ADDR;
    assign remain_one = (r_remain == LENGTH_BITS'(1));

    // next state
    always_comb begin
        n_mode     = r_mode;
        n_pos      = r_pos;
        n_alive    = r_alive;
        n_src      = r_src;
        n_decl     = r_decl;
        n_remain   = r_remain;
        n_held     = r_held;
        n_held_vld = r_held_vld;
        n_closed   = r_closed;
        if (active) begin
            if (is_nl) begin
                n_held_vld = 1'b0;
                n_pos      = 8'd0;
                n_mode     = MODE_MATCH;
                n_alive    = '1;
                n_remain   = '0;
            end else begin
                if (r_pos != POS_MAX) begin
                    n_pos = r_pos + 8'd1;
                end
                case (r_mode)
                    MODE_MATCH: begin
                        n_alive = alive_next;
                        if (alive_next == '0) begin
                            n_mode = MODE_SKIP;
                        end else if (done[P_NAME]) begin
                            n_mode     = MODE_NAME;
                            n_held_vld = 1'b0;
                        end else if (done[P_IPD]) begin
                            n_mode   = MODE_LINK;
                            n_src    = '0;
                            n_decl   = '0;
                            n_closed = 1'b0;
                        end else if (done[P_ADDR]) begin
                            n_mode     = MODE_ADDR;
                            n_held_vld = 1'b0;
                        end else if (done[P_UP]) begin
                            n_mode = MODE_SKIP;
                        end
                    end
                    MODE_NAME, MODE_ADDR: begin
                        if (is_quote) begin
                            n_held_vld = 1'b0;
                            n_mode     = MODE_SKIP;
                        end else begin
                            n_held     = i_byte;
                            n_held_vld = 1'b1;
                        end
                    end
                    MODE_LINK: begin
                        if (i_byte == CHAR_COMMA) begin
                            n_mode   = MODE_COUNT;
                            n_closed = 1'b0;
                        end else if (!r_closed && is_dig) begin
                            n_src = src_sum;
                        end else begin
                            n_closed = 1'b1;
                        end
                    end
                    MODE_COUNT: begin
                        if (i_byte == CHAR_COLON) begin
                            n_remain = r_decl;
                            n_mode   = (r_decl != '0) ? MODE_DATA : MODE_SKIP;
                        end else if (!r_closed && is_dig) begin
                            n_decl = decl_sum;
                        end else begin
                            n_closed = 1'b1;
                        end
                    end
                    MODE_DATA: begin
                        if (r_remain != '0) begin
                            n_remain = r_remain - LENGTH_BITS'(1);
                        end
                        if (r_remain <= LENGTH_BITS'(1)) begin
                            n_mode = MODE_SKIP;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        if (active) begin
            if (is_nl) begin
                if (r_held_vld && (r_mode == MODE_NAME || r_mode == MODE_ADDR)) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = field_kind;
                    o_res.data  = r_held;
                end
            end else begin
                case (r_mode)
                    MODE_MATCH: begin
                        if (done[P_UP]) begin
                            o_res_valid = 1'b1;
                            o_res.kind  = KIND_LINK_UP;
                        end
                    end
                    MODE_NAME, MODE_ADDR: begin
                        if (r_held_vld) begin
                            o_res_valid = 1'b1;
                            o_res.kind  = field_kind;
                            o_res.data  = r_held;
                            o_res.last  = is_quote;
                        end
                    end
                    MODE_DATA: begin
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_PAYLOAD;
                        o_res.data  = i_byte;
                        o_res.last  = remain_one;
                        o_res.src   = r_src;
                        o_res.len   = decl_ext[7:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_MATCH;
            r_pos      <= '0;
            r_alive    <= '1;
            r_src      <= '0;
            r_decl     <= '0;
            r_remain   <= '0;
            r_held_vld <= 1'b0;
            r_closed   <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_pos      <= n_pos;
            r_alive    <= n_alive;
            r_src      <= n_src;
            r_decl     <= n_decl;
            r_remain   <= n_remain;
            r_held_vld <= n_held_vld;
            r_closed   <= n_closed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    `AT_ASSERT(a_data_has_count, i_clk, i_rst_n, r_mode == MODE_DATA |-> r_remain != '0)
    `AT_ASSERT(a_held_in_field, i_clk, i_rst_n, r_held_vld |-> (r_mode == MODE_NAME || r_mode == MODE_ADDR))
    `AT_ASSERT(a_src_range, i_clk, i_rst_n, r_src <= SRC_MAX)
    `AT_ASSERT(a_last_ends_data, i_clk, i_rst_n, (o_res_valid && o_res.kind == KIND_PAYLOAD && o_res.last) |=> r_mode == MODE_SKIP)

endmodule

### sv/at_rlp_out_fifo.sv
// Two-entry result buffer between the parser core and the output channel.
// Depends on at_rlp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module at_rlp_out_fifo
    import at_rlp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    t_result    r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_ready = (r_count != 2'd2);
    assign pop     = o_valid && !i_stall;
    assign o_res   = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ pop;
        n_count  = r_count + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_res;
        end
    end

    `AT_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> r_count != 2'd2)
    `AT_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= 2'd2)
    `AT_ASSERT(a_ptr_count, i_clk, i_rst_n, (r_count == 2'd0 || r_count == 2'd2) |-> r_wr_ptr == r_rd_ptr)

endmodule

### sv/at_response_line_parser.sv
// Top level of the AT response line parser: input register, parser core, result buffer.
// Depends on at_rlp_pkg, at_rlp_parse, at_rlp_out_fifo and assert_macros.svh.
//
// Use: feed received modem bytes on i_rx_byte with i_valid; a request is taken at a
// rising edge with i_valid high and o_stall low. Null bytes are dropped, a newline
// closes the line. Lines starting +CWJAP:" and +CIFSR:STAIP," give their quoted
// name/address bytes (one byte behind, so the byte before the quote carries the last
// mark); +IPD,<link>,<count>: gives <count> payload bytes tagged with link and count;
// WIFI GOT IP gives one link-up result.
// Results leave on o_valid / i_stall with the fields on o_result_kind, o_data_byte,
// o_last_of_field, o_link_source and o_payload_length.
// Path: a byte accepted into the input register is parsed combinationally and its
// result is written into the result buffer, whose slot drives the output.
// Throughput: one byte per cycle while the result buffer has room; the per-byte
// state update sits between the input register and the two-entry result buffer.
// Stalling: a two-entry buffer holds results while i_stall is high; once it is full
// the input register holds its byte and o_stall rises. o_stall never looks at
// i_stall in the same cycle.
// Reset (i_rst_n low, synchronous): line matching restarts, the buffer empties and
// no request is held.

module at_response_line_parser
    import at_rlp_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_result_kind,
    output logic [7:0] o_data_byte,
    output logic       o_last_of_field,
    output logic [3:0] o_link_source,
    output logic [7:0] o_payload_length
);

    logic       r_in_vld, n_in_vld;
    logic [7:0] r_in_byte;
    logic       accept, fire, buf_ready;
    logic       res_valid;
    t_result    res, out_res;

    // the byte waits in the input register until the buffer has room
    assign fire    = r_in_vld && buf_ready;
    assign o_stall = r_in_vld && !buf_ready;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_in_vld = r_in_vld;
        if (accept) begin
            n_in_vld = 1'b1;
        end else if (fire) begin
            n_in_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    at_rlp_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    at_rlp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_ready (buf_ready),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (out_res)
    );

    assign o_result_kind    = out_res.kind;
    assign o_data_byte      = out_res.data;
    assign o_last_of_field  = out_res.last;
    assign o_link_source    = out_res.src;
    assign o_payload_length = out_res.len;

    `AT_ASSERT_ALWAYS(a_reset_clears_in, i_clk, !i_rst_n |=> !r_in_vld)
    `AT_ASSERT(a_hold_while_stalled, i_clk, i_rst_n, o_stall |=> r_in_vld && $stable(r_in_byte))
    `AT_ASSERT(a_push_only_on_fire, i_clk, i_rst_n, res_valid |-> fire)

endmodule
